### rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants for the three-rotor reflector cipher.
// ----------------------------------------------------------------------------
package trc_pkg;

	localparam int LETTER_W   = 5;
	localparam int NUM_TABLES = 4;

	// Table selector codes, as carried in the load beat.
	localparam logic [1:0] TBL_ROTOR_ONE   = 2'd0;
	localparam logic [1:0] TBL_ROTOR_TWO   = 2'd1;
	localparam logic [1:0] TBL_ROTOR_THREE = 2'd2;
	localparam logic [1:0] TBL_REFLECTOR   = 2'd3;

	// Beat kinds on the input tuser bit.
	localparam logic ACT_ENCIPHER = 1'b0;
	localparam logic ACT_LOAD     = 1'b1;

	typedef logic [LETTER_W-1:0] letter_t;

	// One entry of each table, indexed by table selector code.
	typedef letter_t [NUM_TABLES-1:0] row_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic [NUM_TABLES-1:0] wr;
		logic [NUM_TABLES-1:0] rot;
		letter_t               wr_index;
		letter_t               wr_value;
		logic [1:0]            q_table;
		letter_t               q_letter;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} seq_state_t;

endpackage

### rtl/trc_cell.sv
// ----------------------------------------------------------------------------
// trc_cell
// One position of the rotor row: holds that entry of all four tables, shifts
// from its left neighbor on rotation, and answers lookups and searches.
// ----------------------------------------------------------------------------
module trc_cell #(
	parameter logic [4:0] POS = 5'd0
) (
	input  logic              clk,
	input  trc_pkg::cell_ctrl_t ctrl,
	input  trc_pkg::row_t     left_row,
	output trc_pkg::row_t     row,
	output trc_pkg::letter_t  fwd,
	output logic              hit
);
	import trc_pkg::*;

	row_t    row_q;
	letter_t sel;

	always_ff @(posedge clk) begin
		for (int t = 0; t < NUM_TABLES; t++) begin
			if (ctrl.rot[t]) begin
				row_q[t] <= left_row[t];
			end else if (ctrl.wr[t] && (ctrl.wr_index == POS)) begin
				row_q[t] <= ctrl.wr_value;
			end
		end
	end

	always_comb begin
		sel = row_q[ctrl.q_table];
		fwd = (ctrl.q_letter == POS) ? sel : '0;
		hit = (sel == ctrl.q_letter);
	end

	assign row = row_q;

endmodule

### rtl/three_rotor_reflector_cipher.sv
// An encipher beat makes its seven table passes, one per cycle, on the shared
// row of cells in the run state; the finish state writes the result once the
// output register is free. A load beat is written in the cycle it is accepted.
// Throughput: one load beat per cycle while idle; no input while enciphering.
// Reset: arst_n clears the sequencer, step counters and output valid; the
// table entries hold nothing defined until they are loaded.
// ----------------------------------------------------------------------------
// three_rotor_reflector_cipher
// Three rotors and a reflector held as a ring of cells, one cell per letter.
// ----------------------------------------------------------------------------
module three_rotor_reflector_cipher #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata, lowest bit up: letter_in[4:0], table_select[6:5],
	// entry_index[11:7], entry_value[16:12], zero pad[23:17].
	input  logic [23:0] s_tdata,
	// tuser: action (0 encipher, 1 load a table entry).
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata, lowest bit up: letter_out[4:0], zero pad[7:5].
	output logic [7:0]  m_tdata,
	// tuser: table_fault.
	output logic        m_tuser
);
	import trc_pkg::*;

	localparam logic [2:0] LAST_STEP = 3'd6;
	localparam letter_t    WRAP      = LETTER_W'(ALPHABET_SIZE - 1);

	// Input beat fields.
	letter_t    letter_in;
	logic [1:0] table_select;
	letter_t    entry_index;
	letter_t    entry_value;

	assign letter_in    = s_tdata[4:0];
	assign table_select = s_tdata[6:5];
	assign entry_index  = s_tdata[11:7];
	assign entry_value  = s_tdata[16:12];

	// Sequencer state.
	seq_state_t state_q, state_d;
	logic [2:0] step_q;
	letter_t    x_q;
	logic       fault_q;
	letter_t    steps3_q, steps2_q;

	// Output register.
	logic    out_valid_q;
	letter_t out_letter_q;
	logic    out_fault_q;

	// Cell row.
	cell_ctrl_t ctrl;
	row_t       rows   [ALPHABET_SIZE];
	letter_t    fwds   [ALPHABET_SIZE];
	logic       hits   [ALPHABET_SIZE];

	logic       accept;
	logic       finish_fire;
	logic       inv_mode;
	logic [1:0] q_table;
	letter_t    fwd_or;
	logic       found;
	letter_t    found_idx;
	letter_t    x_next;

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign finish_fire = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	// Which table each pass uses: forward through rotors one, two, three and
	// the reflector, then back through the inverses of three, two and one.
	always_comb begin
		inv_mode = 1'b0;
		case (step_q)
			3'd0: q_table = TBL_ROTOR_ONE;
			3'd1: q_table = TBL_ROTOR_TWO;
			3'd2: q_table = TBL_ROTOR_THREE;
			3'd3: q_table = TBL_REFLECTOR;
			3'd4: begin
				q_table  = TBL_ROTOR_THREE;
				inv_mode = 1'b1;
			end
			3'd5: begin
				q_table  = TBL_ROTOR_TWO;
				inv_mode = 1'b1;
			end
			3'd6: begin
				q_table  = TBL_ROTOR_ONE;
				inv_mode = 1'b1;
			end
			default: q_table = TBL_ROTOR_ONE;
		endcase
	end

	// Table writes happen only from an accepted load beat; rotation only at the
	// end of an encipher beat, so the two never meet in one cycle.
	always_comb begin
		ctrl.q_table  = q_table;
		ctrl.q_letter = x_q;
		ctrl.wr_index = entry_index;
		ctrl.wr_value = entry_value;
		for (int t = 0; t < NUM_TABLES; t++) begin
			ctrl.wr[t] = accept && (s_tuser == ACT_LOAD) && (table_select == 2'(t));
		end
		ctrl.rot[TBL_ROTOR_THREE] = finish_fire;
		ctrl.rot[TBL_ROTOR_TWO]   = finish_fire && (steps3_q >= WRAP);
		ctrl.rot[TBL_ROTOR_ONE]   = finish_fire && (steps3_q >= WRAP) && (steps2_q >= WRAP);
		ctrl.rot[TBL_REFLECTOR]   = 1'b0;
	end

	// The ring: each cell takes its left neighbor's entries on rotation, and
	// the first cell takes the last, which turns the contents right by one.
	for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
		trc_cell #(
			.POS(5'(i))
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.left_row(rows[(i + ALPHABET_SIZE - 1) % ALPHABET_SIZE]),
			.row     (rows[i]),
			.fwd     (fwds[i]),
			.hit     (hits[i])
		);
	end

	// A forward lookup is the OR of all cells, of which at most one answers; an
	// index outside the alphabet matches no cell and reads as zero. An inverse
	// search takes the lowest cell whose entry matches.
	always_comb begin
		fwd_or    = '0;
		found     = 1'b0;
		found_idx = '0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			fwd_or = fwd_or | fwds[i];
		end
		for (int i = ALPHABET_SIZE - 1; i >= 0; i--) begin
			if (hits[i]) begin
				found     = 1'b1;
				found_idx = 5'(i);
			end
		end
		if (inv_mode) begin
			x_next = found ? found_idx : '0;
		end else begin
			x_next = fwd_or;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (s_tuser == ACT_ENCIPHER)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (finish_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			steps3_q <= '0;
			steps2_q <= '0;
		end else begin
			if (accept) begin
				step_q <= '0;
			end else if (state_q == ST_RUN) begin
				step_q <= step_q + 3'd1;
			end
			if (finish_fire) begin
				if (steps3_q >= WRAP) begin
					steps3_q <= '0;
					if (steps2_q >= WRAP) begin
						steps2_q <= '0;
					end else begin
						steps2_q <= steps2_q + 5'd1;
					end
				end else begin
					steps3_q <= steps3_q + 5'd1;
				end
			end
		end
	end

	// The letter in flight and its fault flag.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= letter_in;
			fault_q <= 1'b0;
		end else if (state_q == ST_RUN) begin
			x_q     <= x_next;
			fault_q <= fault_q | (inv_mode && !found);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			out_letter_q <= x_q;
			out_fault_q  <= fault_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_letter_q};
	assign m_tuser  = out_fault_q;

endmodule

### tb/cipher_checker.sv
// ----------------------------------------------------------------------------
// cipher_checker
// Watches both stream channels of the three-rotor reflector cipher. It keeps
// its own copy of the rotor and reflector tables and step counters, predicts
// the result of every encipher beat, and compares each output beat with the
// oldest prediction.
// ----------------------------------------------------------------------------
module cipher_checker #(
	parameter int ALPHABET = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// tdata, lowest bit up: letter_in[4:0], table_select[6:5],
	// entry_index[11:7], entry_value[16:12], zero pad[23:17].
	input  logic [23:0] s_tdata,
	// tuser: action.
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// tdata, lowest bit up: letter_out[4:0], zero pad[7:5].
	input  logic [7:0]  m_tdata,
	// tuser: table_fault.
	input  logic        m_tuser,
	output int          failures,
	output int          n_expected
);
	timeunit 1ns;
	timeprecision 1ps;

	import trc_pkg::*;

	typedef struct packed {
		letter_t letter;
		logic    fault;
	} cipher_result_t;

	letter_t        cipher_tables [NUM_TABLES][ALPHABET];
	int             rotor_three_count = 0;
	int             rotor_two_count = 0;
	cipher_result_t expected_letters [$];
	int             mismatch_count = 0;

	assign failures = mismatch_count;

	task automatic report_mismatch(input string msg);
		$display("cipher_checker: %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic letter_t forward_pass(input logic [1:0] sel, input letter_t idx);
		if (int'(idx) >= ALPHABET) begin
			return '0;
		end
		return cipher_tables[sel][idx];
	endfunction

	// Lowest position holding the letter; a miss yields letter zero and a fault.
	function automatic letter_t reverse_search(input logic [1:0] sel, input letter_t letter,
			inout logic fault);
		for (int i = 0; i < ALPHABET; i++) begin
			if (cipher_tables[sel][i] == letter) begin
				return letter_t'(i);
			end
		end
		fault = 1'b1;
		return '0;
	endfunction

	function automatic void spin_table(input logic [1:0] sel);
		letter_t last;
		last = cipher_tables[sel][ALPHABET-1];
		for (int i = ALPHABET - 1; i > 0; i--) begin
			cipher_tables[sel][i] = cipher_tables[sel][i-1];
		end
		cipher_tables[sel][0] = last;
	endfunction

	task automatic predict_cipher_beat(input logic act, input logic [23:0] data);
		letter_t    letter;
		letter_t    idx;
		letter_t    val;
		letter_t    x;
		logic [1:0] sel;
		logic       fault;
		letter = data[4:0];
		sel    = data[6:5];
		idx    = data[11:7];
		val    = data[16:12];
		if (act == ACT_LOAD) begin
			if (int'(idx) < ALPHABET) begin
				cipher_tables[sel][idx] = val;
			end
		end else begin
			fault = 1'b0;
			x = forward_pass(TBL_ROTOR_ONE, letter);
			x = forward_pass(TBL_ROTOR_TWO, x);
			x = forward_pass(TBL_ROTOR_THREE, x);
			x = forward_pass(TBL_REFLECTOR, x);
			x = reverse_search(TBL_ROTOR_THREE, x, fault);
			x = reverse_search(TBL_ROTOR_TWO, x, fault);
			x = reverse_search(TBL_ROTOR_ONE, x, fault);
			expected_letters.push_back(cipher_result_t'{letter: x, fault: fault});
			spin_table(TBL_ROTOR_THREE);
			if (rotor_three_count >= ALPHABET - 1) begin
				rotor_three_count = 0;
				spin_table(TBL_ROTOR_TWO);
				if (rotor_two_count >= ALPHABET - 1) begin
					rotor_two_count = 0;
					spin_table(TBL_ROTOR_ONE);
				end else begin
					rotor_two_count++;
				end
			end else begin
				rotor_three_count++;
			end
		end
	endtask

	initial begin
		for (int t = 0; t < NUM_TABLES; t++) begin
			for (int i = 0; i < ALPHABET; i++) begin
				cipher_tables[t][i] = '0;
			end
		end
	end

	// Output beats are matched before the input beat of the same edge is
	// predicted, since no result can belong to a beat accepted that edge.
	always @(posedge clk or negedge arst_n) begin
		cipher_result_t want;
		if (!arst_n) begin
			expected_letters.delete();
			rotor_three_count = 0;
			rotor_two_count = 0;
			n_expected <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_letters.size() == 0) begin
					report_mismatch($sformatf("result beat letter_out=%0d with none expected",
						m_tdata[4:0]));
				end else begin
					want = expected_letters.pop_front();
					if (m_tdata[4:0] !== want.letter) begin
						report_mismatch($sformatf("letter_out got %0d, expected %0d",
							m_tdata[4:0], want.letter));
					end
					if (m_tuser !== want.fault) begin
						report_mismatch($sformatf("table_fault got %b, expected %b",
							m_tuser, want.fault));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_cipher_beat(s_tuser, s_tdata);
			end
			n_expected <= expected_letters.size();
		end
	end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-rotor reflector cipher. All four tables
// are loaded with permutations before any letter is enciphered, then a short
// directed part covers corner letters, ignored and out-of-range loads and
// broken tables, followed by random runs of letters and table reloads under
// three idling phases. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import trc_pkg::*;

	localparam int ALPHABET       = 26;
	// Counted items: encipher beats and load beats that land in a table.
	localparam int ITEM_TARGET    = 1450;
	// The receiver's long hold-off is the longest quiet stretch of a correct
	// run, so the watchdog allows that hold several times over.
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	// After the last expected result, wait on to catch any stray beat.
	localparam int DRAIN_CYCLES   = 20;

	localparam letter_t CORNER_LETTERS [6] = '{5'd0, 5'd25, 5'd26, 5'd31, 5'd1, 5'd12};

	// Idling phases: first the receiver is the slow side, then the sender,
	// then neither side idles.
	typedef enum logic [1:0] {
		PH_RECV_SLOW,
		PH_SEND_SLOW,
		PH_NO_IDLE
	} idle_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// tdata, lowest bit up: letter_in[4:0], table_select[6:5],
	// entry_index[11:7], entry_value[16:12], zero pad[23:17].
	logic [23:0] s_tdata = '0;
	// tuser: action (0 encipher, 1 load a table entry).
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// tdata, lowest bit up: letter_out[4:0], zero pad[7:5].
	logic [7:0]  m_tdata;
	// tuser: table_fault.
	logic        m_tuser;

	idle_phase_t phase = PH_RECV_SLOW;
	int          items_sent = 0;
	bit          hold_done = 1'b0;
	int          quiet_cycles = 0;
	int          failures;
	int          n_expected;
	// Rotor one only turns once every ALPHABET squared letters, so the
	// directed part can repair an entry of it at the position it was loaded.
	letter_t     rotor_one_perm [ALPHABET];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	three_rotor_reflector_cipher #(
		.ALPHABET_SIZE(ALPHABET)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	cipher_checker #(
		.ALPHABET(ALPHABET)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.failures  (failures),
		.n_expected(n_expected)
	);

	// Offers one beat, with random idle cycles in front of it, and returns at
	// the edge where it was accepted. The next beat's drive then lands in the
	// same step, so tvalid stays high without being lowered in between.
	// While idle, the data lines carry noise.
	task automatic send_beat(input logic act, input letter_t letter, input logic [1:0] sel,
			input letter_t idx, input letter_t val);
		int idle_pct;
		idle_pct = (phase == PH_RECV_SLOW) ? 18 : (phase == PH_SEND_SLOW) ? 56 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			s_tuser  <= 1'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, val, idx, sel, letter};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		// Loads past the end of the alphabet are dropped by the block and do
		// not count as items.
		if (act == ACT_ENCIPHER || int'(idx) < ALPHABET) begin
			items_sent++;
		end
		if (items_sent >= 2 * ITEM_TARGET / 3) begin
			phase = PH_NO_IDLE;
		end else if (items_sent >= ITEM_TARGET / 3) begin
			phase = PH_SEND_SLOW;
		end
	endtask

	// Writes a whole table with a fresh permutation; the reflector gets a
	// pairing of letters, as a real reflector is its own inverse. A noise
	// share of entries is replaced by an arbitrary 5-bit value, which breaks
	// the permutation and gives failed inverse searches.
	task automatic load_table(input logic [1:0] sel, input int noise_pct);
		letter_t order [ALPHABET];
		letter_t perm [ALPHABET];
		letter_t tmp;
		letter_t val;
		int      j;
		for (int i = 0; i < ALPHABET; i++) begin
			order[i] = letter_t'(i);
		end
		for (int i = ALPHABET - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (sel == TBL_REFLECTOR) begin
			for (int i = 0; i + 1 < ALPHABET; i += 2) begin
				perm[order[i]]   = order[i+1];
				perm[order[i+1]] = order[i];
			end
			if (ALPHABET % 2 == 1) begin
				perm[order[ALPHABET-1]] = order[ALPHABET-1];
			end
		end else begin
			perm = order;
		end
		if (sel == TBL_ROTOR_ONE) begin
			rotor_one_perm = perm;
		end
		for (int i = 0; i < ALPHABET; i++) begin
			val = perm[i];
			if ($urandom_range(0, 99) < noise_pct) begin
				val = 5'($urandom);
			end
			send_beat(ACT_LOAD, 5'($urandom), sel, letter_t'(i), val);
		end
	endtask

	// Receiver: random ready per phase, and one long hold-off when the
	// no-idle phase starts. The sender keeps offering beats meanwhile, so
	// the output register fills and the block stops taking input.
	initial begin
		int idle_pct;
		forever begin
			@(posedge clk);
			if (phase == PH_NO_IDLE && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else begin
				idle_pct = (phase == PH_RECV_SLOW) ? 56 : (phase == PH_SEND_SLOW) ? 18 : 0;
				m_tready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int      pick;
		int      run_len;
		letter_t letter;
		letter_t saved;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry of every table is written before the first letter, so
		// no lookup or inverse search ever touches an undefined entry.
		load_table(TBL_ROTOR_ONE, 0);
		load_table(TBL_ROTOR_TWO, 0);
		load_table(TBL_ROTOR_THREE, 0);
		load_table(TBL_REFLECTOR, 0);

		// Corner letters, including codes past the alphabet that read as zero.
		foreach (CORNER_LETTERS[k]) begin
			send_beat(ACT_ENCIPHER, CORNER_LETTERS[k], 2'($urandom), 5'($urandom),
				5'($urandom));
		end

		// Loads past the alphabet end must leave the tables alone.
		send_beat(ACT_LOAD, 5'd0, TBL_ROTOR_THREE, 5'd26, 5'd0);
		send_beat(ACT_LOAD, 5'd31, TBL_REFLECTOR, 5'd31, 5'd31);
		send_beat(ACT_ENCIPHER, 5'd7, 2'd0, 5'd0, 5'd0);

		// A duplicated rotor one entry leaves a letter with no inverse, so a
		// search for it shows a table fault; the entry is then put back.
		saved = rotor_one_perm[3];
		send_beat(ACT_LOAD, 5'd0, TBL_ROTOR_ONE, 5'd3, rotor_one_perm[4]);
		for (int i = 0; i < 8; i++) begin
			send_beat(ACT_ENCIPHER, letter_t'(i), 2'd3, 5'd31, 5'd31);
		end
		send_beat(ACT_LOAD, 5'd0, TBL_ROTOR_ONE, 5'd3, saved);

		// An entry value past the alphabet is stored as is; rotor two passes it
		// on, and the rotor three lookup at that index reads zero.
		send_beat(ACT_LOAD, 5'd0, TBL_ROTOR_TWO, 5'd0, 5'd31);
		for (int i = 0; i < 4; i++) begin
			send_beat(ACT_ENCIPHER, 5'($urandom_range(0, 25)), 2'd0, 5'd0, 5'd0);
		end
		load_table(TBL_ROTOR_TWO, 0);

		// Random part: mostly runs of letters over well-formed tables, with
		// whole-table reloads and stray single loads as noise.
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				load_table(2'($urandom), ($urandom_range(0, 1) == 0) ? 0 : 8);
			end else if (pick < 20) begin
				send_beat(ACT_LOAD, 5'($urandom), 2'($urandom), 5'($urandom),
					5'($urandom));
			end else begin
				run_len = $urandom_range(1, 12);
				repeat (run_len) begin
					if ($urandom_range(0, 9) == 0) begin
						letter = 5'($urandom_range(26, 31));
					end else begin
						letter = 5'($urandom_range(0, 25));
					end
					send_beat(ACT_ENCIPHER, letter, 2'($urandom), 5'($urandom),
						5'($urandom));
				end
			end
		end
		s_tvalid <= 1'b0;

		// Let the checker see the last beat, then wait for every result and
		// a little longer to catch any stray beat.
		@(posedge clk);
		while (n_expected != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && n_expected == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
